// ===== sv/rbfna_pkg.sv =====
// Shared constants and types for the RBF neuron activation unit.
package rbfna_pkg;

   // Vector length limit and the widths that follow from it.
   localparam int MAX_DIM = 64;
   localparam int CNT_W   = $clog2(MAX_DIM + 1);
   localparam int SUM_W   = 48;
   localparam int SQ_W    = 32;
   localparam int S_W     = SUM_W + CNT_W;
   localparam int Q_W     = S_W + 1;
   localparam int R2_W    = 32;
   localparam int DIV_W   = 64;
   localparam int STEP_W  = 6;
   localparam int SER_W   = 61;
   localparam int TAB_N   = 21;
   localparam int TAB_W   = 32;
   localparam int IDX_W   = 5;
   localparam int ACC_W   = 33;
   localparam int T_W     = 21;
   localparam int N_W     = 6;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // Exponential table layout: series factors first, squared factors after.
   localparam logic [IDX_W-1:0] SERIES_LAST = IDX_W'(16);
   localparam logic [IDX_W-1:0] TAB_LAST    = IDX_W'(TAB_N - 1);

   // Activation modes. The unused code falls back to the Gaussian.
   localparam logic [1:0] MODE_GAUSS  = 2'd0;
   localparam logic [1:0] MODE_MQ     = 2'd1;
   localparam logic [1:0] MODE_IMQ    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Register indexes.
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_RADIUS   = 2'd1;
   localparam logic [1:0] CSR_WEIGHTED = 2'd2;

   // Request payload, first field in the highest bits.
   typedef struct packed {
      logic [15:0]        coord_weight;
      logic signed [15:0] center_value;
      logic signed [15:0] coord_value;
   } req_data_type;

endpackage

// ===== sv/rbf_neuron_activation_unit.sv =====
// RBF neuron activation unit: distance accumulation and kernel evaluation.
// Each coordinate beat is squared on acceptance, then accumulated (weighted
// when enabled). A last beat then runs the shared divider and/or the square-root
// unit: the Gaussian uses the divider, the multiquadric the square root and the
// inverse multiquadric both. The sequencer holds req_tready low meanwhile.
// After reset a table build pass fills the exponential factors, series factors
// with the divider and larger ones by squaring, before the first beat is taken.
module rbf_neuron_activation_unit
   import rbfna_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coord_value[15:0], center_value[31:16], coord_weight[47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // activation[31:0]
   output logic        rsp_tuser,   // saturated[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] ST_TB_INIT  = 4'd0;
   localparam logic [3:0] ST_TB_DIV   = 4'd1;
   localparam logic [3:0] ST_TB_TERM  = 4'd2;
   localparam logic [3:0] ST_TB_SQ    = 4'd3;
   localparam logic [3:0] ST_IDLE     = 4'd4;
   localparam logic [3:0] ST_ACC      = 4'd5;
   localparam logic [3:0] ST_SCALE    = 4'd6;
   localparam logic [3:0] ST_DISPATCH = 4'd7;
   localparam logic [3:0] ST_DIV      = 4'd8;
   localparam logic [3:0] ST_G_START  = 4'd9;
   localparam logic [3:0] ST_G_MUL    = 4'd10;
   localparam logic [3:0] ST_G_FIN    = 4'd11;
   localparam logic [3:0] ST_IMQ_SQ   = 4'd12;
   localparam logic [3:0] ST_SQRT     = 4'd13;
   localparam logic [3:0] ST_DONE     = 4'd14;
   localparam logic [3:0] ST_SPARE    = 4'd15;

   req_data_type req_data;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [15:0]       radius_ff, radius_in;
   logic              wmode_ff, wmode_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [15:0]       w_ff, w_in;
   logic              last_ff, last_in;
   logic [S_W-1:0]    s_ff, s_in;
   logic [R2_W-1:0]   r2_ff, r2_in;
   logic [DIV_W-1:0]  div_num_ff, div_num_in;
   logic [Q_W-1:0]    div_rem_ff, div_rem_in;
   logic [Q_W-1:0]    div_den_ff, div_den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [3:0]        ret_ff, ret_in;
   logic [63:0]       sqv_ff, sqv_in;
   logic [63:0]       sqr_ff, sqr_in;
   logic [63:0]       sqb_ff, sqb_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [SER_W-1:0]  term_ff, term_in;
   logic [SER_W-1:0]  ser_ff, ser_in;
   logic [TAB_W-1:0]  tab_ff [TAB_N];
   logic [TAB_W-1:0]  tab_in [TAB_N];
   logic [T_W-1:0]    t_ff, t_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [31:0]       res_act_ff, res_act_in;
   logic              res_sat_ff, res_sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_act_ff, rsp_act_in;
   logic              rsp_sat_ff, rsp_sat_in;

   // Datapath helpers.
   logic signed [16:0] diff;
   logic [16:0]        diff_abs;
   logic [47:0]        wprod;
   logic [SQ_W-1:0]    add_val;
   logic [SUM_W:0]     sum_wide;
   logic [S_W-1:0]     scaled;
   logic [Q_W-1:0]     q_sum;
   logic [Q_W:0]       rem_sh;
   logic               rem_ge;
   logic [63:0]        sq_trial;
   logic               sq_ge;
   logic [63:0]        sqr_step;
   logic [ACC_W-1:0]   mul_a;
   logic [TAB_W-1:0]   mul_b;
   logic [64:0]        mul_p;
   logic [64:0]        mul_rnd;
   logic [IDX_W-1:0]   b_prev;
   logic [IDX_W-1:0]   shift_j;
   logic [SER_W+2:0]   ser_rnd;
   logic [ACC_W-1:0]   acc_rnd;
   logic               accept;

   assign req_data   = req_tdata;
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_act_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // Coordinate difference and weighted square.
   assign diff     = {req_data.coord_value[15], req_data.coord_value}
                   - {req_data.center_value[15], req_data.center_value};
   assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
   assign wprod    = sq_ff * w_ff;
   assign add_val  = wmode_ff ? wprod[47:16] : sq_ff;
   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(add_val);
   assign scaled   = sum_ff * cnt_ff;
   assign q_sum    = Q_W'(s_ff) + Q_W'(r2_ff);

   // Shared restoring divider step: one quotient bit a cycle.
   assign rem_sh = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign rem_ge = rem_sh >= {1'b0, div_den_ff};

   // Shared square-root step: one result bit a cycle.
   assign sq_trial = sqr_ff + sqb_ff;
   assign sq_ge    = sqv_ff >= sq_trial;
   assign sqr_step = sq_ge ? ((sqr_ff >> 1) + sqb_ff) : (sqr_ff >> 1);

   // Shared multiplier with rounding to Q0.32 for the table products.
   assign b_prev = b_ff - IDX_W'(1);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SCALE: begin
            mul_a = ACC_W'(radius_ff);
            mul_b = TAB_W'(radius_ff);
         end
         ST_G_MUL: begin
            mul_a = acc_ff;
            mul_b = tab_ff[b_ff];
         end
         ST_TB_SQ: begin
            mul_a = ACC_W'(tab_ff[b_prev]);
            mul_b = tab_ff[b_prev];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p   = mul_a * mul_b;
   assign mul_rnd = mul_p + (65'(1) << 31);

   assign shift_j = SERIES_LAST - b_ff;
   assign ser_rnd = (SER_W+3)'(ser_ff) + ((SER_W+3)'(1) << 27);
   assign acc_rnd = acc_ff + ACC_W'(16'h8000);

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      radius_in    = radius_ff;
      wmode_in     = wmode_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      sq_in        = sq_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      s_in         = s_ff;
      r2_in        = r2_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      step_in      = step_ff;
      ret_in       = ret_ff;
      sqv_in       = sqv_ff;
      sqr_in       = sqr_ff;
      sqb_in       = sqb_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      term_in      = term_ff;
      ser_in       = ser_ff;
      tab_in       = tab_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      res_act_in   = res_act_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_sat_in   = rsp_sat_ff;

      // Register writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:     mode_in   = csr_wdata[1:0];
            CSR_RADIUS:   radius_in = csr_wdata;
            CSR_WEIGHTED: wmode_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end

      // Result beat leaves the output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Series for exp(-2^(b-16)), one term per divide by n.
         ST_TB_INIT: begin
            term_in  = SER_W'(1) << 60;
            ser_in   = SER_W'(1) << 60;
            n_in     = N_W'(1);
            state_in = ST_TB_DIV;
         end
         ST_TB_DIV: begin
            div_num_in = DIV_W'(term_ff >> shift_j);
            div_den_in = Q_W'(n_ff);
            div_rem_in = '0;
            step_in    = '1;
            ret_in     = ST_TB_TERM;
            state_in   = ST_DIV;
         end
         ST_TB_TERM: begin
            if (div_num_ff == '0) begin
               tab_in[b_ff] = ser_rnd[59:28];
               b_in         = b_ff + IDX_W'(1);
               state_in     = (b_ff == SERIES_LAST) ? ST_TB_SQ : ST_TB_INIT;
            end else begin
               term_in  = div_num_ff[SER_W-1:0];
               ser_in   = n_ff[0] ? (ser_ff - div_num_ff[SER_W-1:0])
                                  : (ser_ff + div_num_ff[SER_W-1:0]);
               n_in     = n_ff + N_W'(1);
               state_in = ST_TB_DIV;
            end
         end
         // Larger factors by rounded squaring of the previous one.
         ST_TB_SQ: begin
            tab_in[b_ff] = mul_rnd[63:32];
            b_in         = b_ff + IDX_W'(1);
            if (b_ff == TAB_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               sq_in    = SQ_W'(diff_abs[15:0] * diff_abs[15:0]);
               w_in     = req_data.coord_weight;
               last_in  = req_tlast;
               state_in = ST_ACC;
            end
         end
         // Accumulate unless the vector is already full.
         ST_ACC: begin
            if (cnt_ff < CNT_W'(MAX_DIM)) begin
               sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = last_ff ? ST_SCALE : ST_IDLE;
         end
         ST_SCALE: begin
            s_in     = wmode_ff ? scaled : S_W'(sum_ff);
            r2_in    = mul_p[R2_W-1:0];
            sum_in   = '0;
            cnt_in   = '0;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            res_sat_in = 1'b0;
            case (mode_ff)
               MODE_MQ: begin
                  if ((q_sum >> 56) != '0) begin
                     res_act_in = '1;
                     res_sat_in = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     sqv_in   = 64'(q_sum) << 8;
                     sqr_in   = '0;
                     sqb_in   = 64'(1) << 62;
                     step_in  = STEP_W'(31);
                     state_in = ST_SQRT;
                  end
               end
               MODE_IMQ: begin
                  if (q_sum == '0) begin
                     res_act_in = '1;
                     res_sat_in = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     div_num_in = DIV_W'(1) << 56;
                     div_den_in = q_sum;
                     div_rem_in = '0;
                     step_in    = '1;
                     ret_in     = ST_IMQ_SQ;
                     state_in   = ST_DIV;
                  end
               end
               default: begin
                  if (r2_ff == '0) begin
                     res_act_in = (s_ff == '0) ? 32'h0001_0000 : 32'h0;
                     state_in   = ST_DONE;
                  end else if ((S_W+5)'(s_ff) >= ((S_W+5)'(r2_ff) << 5)) begin
                     res_act_in = '0;
                     state_in   = ST_DONE;
                  end else begin
                     div_num_in = DIV_W'(s_ff) << 16;
                     div_den_in = Q_W'(r2_ff);
                     div_rem_in = '0;
                     step_in    = '1;
                     ret_in     = ST_G_START;
                     state_in   = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            div_rem_in = rem_ge ? Q_W'(rem_sh - {1'b0, div_den_ff}) : Q_W'(rem_sh);
            div_num_in = {div_num_ff[DIV_W-2:0], rem_ge};
            step_in    = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ret_ff;
            end
         end
         ST_G_START: begin
            t_in     = div_num_ff[T_W-1:0];
            acc_in   = ACC_W'(1) << 32;
            b_in     = '0;
            state_in = ST_G_MUL;
         end
         // One factor per set bit of the scaled distance.
         ST_G_MUL: begin
            if (t_ff[b_ff]) begin
               acc_in = mul_rnd[64:32];
            end
            b_in = b_ff + IDX_W'(1);
            if (b_ff == TAB_LAST) begin
               state_in = ST_G_FIN;
            end
         end
         ST_G_FIN: begin
            res_act_in = 32'(acc_rnd >> 16);
            state_in   = ST_DONE;
         end
         ST_IMQ_SQ: begin
            sqv_in   = div_num_ff;
            sqr_in   = '0;
            sqb_in   = 64'(1) << 62;
            step_in  = STEP_W'(31);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_ge) begin
               sqv_in = sqv_ff - sq_trial;
            end
            sqr_in  = sqr_step;
            sqb_in  = sqb_ff >> 2;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               res_act_in = sqr_step[31:0];
               state_in   = ST_DONE;
            end
         end
         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = res_act_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SPARE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TB_INIT;
         mode_ff      <= MODE_GAUSS;
         radius_ff    <= 16'd4096;
         wmode_ff     <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         b_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         radius_ff    <= radius_in;
         wmode_ff     <= wmode_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         b_ff         <= b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      sq_ff      <= sq_in;
      w_ff       <= w_in;
      last_ff    <= last_in;
      s_ff       <= s_in;
      r2_ff      <= r2_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      step_ff    <= step_in;
      ret_ff     <= ret_in;
      sqv_ff     <= sqv_in;
      sqr_ff     <= sqr_in;
      sqb_ff     <= sqb_in;
      n_ff       <= n_in;
      term_ff    <= term_in;
      ser_ff     <= ser_in;
      tab_ff     <= tab_in;
      t_ff       <= t_in;
      acc_ff     <= acc_in;
      res_act_ff <= res_act_in;
      res_sat_ff <= res_sat_in;
      rsp_act_ff <= rsp_act_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   // The coordinate count never passes the vector limit.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIM))
      else $error("coordinate count above limit");

   // The Gaussian quotient stays below 32 in Q.16.
   a_gauss_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G_START) |-> (div_num_ff[DIV_W-1:T_W] == '0))
      else $error("gaussian quotient out of range");

   // An accepted beat is squared and then accumulated before the next one.
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ACC) && !req_tready)
      else $error("beat not followed by accumulate");

   // A finished result reaches a free output register in the following cycle.
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not delivered");

endmodule
